// ----- hw/rtl/tfcm_pkg.sv -----
package tfcm_pkg;

    // Default width of temperatures and range registers.
    localparam int TEMP_BITS_DEF = 16;

    // Breakpoints are held with this many fraction bits of the span.
    localparam int SCALE_BITS = 16;

    // Breakpoint fractions of the span in Q0.16.
    localparam logic [15:0] K_A = 16'd13900;
    localparam logic [15:0] K_B = 16'd20854;
    localparam logic [15:0] K_C = 16'd27800;
    localparam logic [15:0] K_D = 16'd53622;

    // Quotient bits produced by the divider; one more than a level so that
    // values above the channel ceiling are seen and clamped.
    localparam int Q_BITS = 9;
    localparam int LEVEL_BITS = 8;

    // Channel ceilings.
    localparam logic [LEVEL_BITS-1:0] TOP_FULL    = 8'd255;
    localparam logic [LEVEL_BITS-1:0] TOP_BLUE_HI = 8'd240;

    // Colour lanes.
    localparam int LANES    = 3;
    localparam int LANE_RED = 0;
    localparam int LANE_GRN = 1;
    localparam int LANE_BLU = 2;

    // Range registers after reset: 20 and 40 degrees at 1/64 degree units.
    localparam int RANGE_MIN_RESET = 1280;
    localparam int RANGE_MAX_RESET = 2560;

    // Register indexes of the configuration port.
    localparam int CFG_IDX_BITS = 1;
    localparam logic [CFG_IDX_BITS-1:0] REG_RANGE_MIN = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] REG_RANGE_MAX = 1'b1;

    // Output word: three levels and the RGB565 word.
    localparam int PIX_BITS = 3 * LEVEL_BITS + 16;

endpackage

// ----- hw/rtl/tfcm_bkpt.sv -----
// Range registers and the four breakpoints derived from them.
module tfcm_bkpt
    import tfcm_pkg::*;
#(
    parameter int TEMP_BITS = TEMP_BITS_DEF,
    localparam int PW = TEMP_BITS + SCALE_BITS + 1
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [CFG_IDX_BITS-1:0]     cfg_index,
    input  logic [TEMP_BITS-1:0]        cfg_data,
    output logic signed [TEMP_BITS-1:0] range_min,
    output logic signed [PW-1:0]        bp_a,
    output logic signed [PW-1:0]        bp_b,
    output logic signed [PW-1:0]        bp_c,
    output logic signed [PW-1:0]        bp_d,
    output logic signed [PW-1:0]        bp_max
);

    logic signed [TEMP_BITS-1:0] range_min_reg;
    logic signed [TEMP_BITS-1:0] range_max_reg;
    logic signed [TEMP_BITS:0]   span;
    logic signed [PW-1:0]        bp_a_reg, bp_b_reg, bp_c_reg, bp_d_reg, bp_max_reg;
    logic signed [PW-1:0]        bp_a_next, bp_b_next, bp_c_next, bp_d_next, bp_max_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_min_reg <= TEMP_BITS'(RANGE_MIN_RESET);
            range_max_reg <= TEMP_BITS'(RANGE_MAX_RESET);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_RANGE_MIN: range_min_reg <= cfg_data;
                REG_RANGE_MAX: range_max_reg <= cfg_data;
                default:       range_min_reg <= range_min_reg;
            endcase
        end
    end

    // Breakpoints relative to the cold end: span times the fraction.
    always_comb
    begin
        span        = $signed({range_max_reg[TEMP_BITS-1], range_max_reg})
                    - $signed({range_min_reg[TEMP_BITS-1], range_min_reg});
        bp_a_next   = PW'(span) * $signed(PW'({1'b0, K_A}));
        bp_b_next   = PW'(span) * $signed(PW'({1'b0, K_B}));
        bp_c_next   = PW'(span) * $signed(PW'({1'b0, K_C}));
        bp_d_next   = PW'(span) * $signed(PW'({1'b0, K_D}));
        bp_max_next = $signed({span, {SCALE_BITS{1'b0}}});
    end

    always_ff @(posedge clk)
    begin
        bp_a_reg   <= bp_a_next;
        bp_b_reg   <= bp_b_next;
        bp_c_reg   <= bp_c_next;
        bp_d_reg   <= bp_d_next;
        bp_max_reg <= bp_max_next;
    end

    assign range_min = range_min_reg;
    assign bp_a      = bp_a_reg;
    assign bp_b      = bp_b_reg;
    assign bp_c      = bp_c_reg;
    assign bp_d      = bp_d_reg;
    assign bp_max    = bp_max_reg;

endmodule

// ----- hw/rtl/tfcm_front.sv -----
// Front of the pipeline: offset of the sample, segment choice per colour,
// and a dividend and divisor for each colour lane.
module tfcm_front
    import tfcm_pkg::*;
#(
    parameter int TEMP_BITS = TEMP_BITS_DEF,
    localparam int PW = TEMP_BITS + SCALE_BITS + 1,
    localparam int W  = PW + 1,
    localparam int DW = W - 1,
    localparam int RW = DW + Q_BITS
)
(
    input  logic                        clk,
    input  logic [2:0]                  en,
    input  logic signed [TEMP_BITS-1:0] sample,
    input  logic signed [TEMP_BITS-1:0] range_min,
    input  logic signed [PW-1:0]        bp_a,
    input  logic signed [PW-1:0]        bp_b,
    input  logic signed [PW-1:0]        bp_c,
    input  logic signed [PW-1:0]        bp_d,
    input  logic signed [PW-1:0]        bp_max,
    output logic [RW-1:0]               lane_num [LANES],
    output logic [DW-1:0]               lane_den [LANES],
    output logic                        lane_hi  [LANES]
);

    typedef enum logic [1:0] {SEG_RAMP, SEG_ZERO, SEG_FULL} seg_kind_t;

    logic signed [TEMP_BITS:0] diff_reg;
    logic signed [TEMP_BITS:0] diff_next;

    logic signed [PW-1:0] v_p;
    logic signed [W-1:0]  va, ba, bb, bc, bd, bmx;
    logic signed [W-1:0]  num1_next [LANES];
    logic signed [W-1:0]  den1_next [LANES];
    seg_kind_t            kind1_next [LANES];
    logic                 hi1_next [LANES];
    logic signed [W-1:0]  num1_reg [LANES];
    logic signed [W-1:0]  den1_reg [LANES];
    seg_kind_t            kind1_reg [LANES];
    logic                 hi1_reg [LANES];

    logic signed [W-1:0]  nm [LANES];
    logic signed [W-1:0]  dn [LANES];
    logic [RW-1:0]        prod [LANES];
    logic [RW-1:0]        num2_next [LANES];
    logic [DW-1:0]        den2_next [LANES];
    logic [RW-1:0]        num2_reg [LANES];
    logic [DW-1:0]        den2_reg [LANES];
    logic                 hi2_reg [LANES];

    // Stage 0: sample relative to the cold end.
    assign diff_next = $signed({sample[TEMP_BITS-1], sample})
                     - $signed({range_min[TEMP_BITS-1], range_min});

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            diff_reg <= diff_next;
        end
    end

    // Stage 1: place the sample against the breakpoints and pick each
    // colour's segment.
    always_comb
    begin
        v_p = $signed({diff_reg, {SCALE_BITS{1'b0}}});
        va  = W'(v_p);
        ba  = W'(bp_a);
        bb  = W'(bp_b);
        bc  = W'(bp_c);
        bd  = W'(bp_d);
        bmx = W'(bp_max);

        for (int i = 0; i < LANES; i++)
        begin
            num1_next[i]  = '0;
            den1_next[i]  = '0;
            kind1_next[i] = SEG_RAMP;
            hi1_next[i]   = 1'b0;
        end

        num1_next[LANE_RED] = va - bb;
        den1_next[LANE_RED] = bc - bb;

        priority if (v_p > 0 && v_p < bp_a)
        begin
            num1_next[LANE_GRN] = va;
            den1_next[LANE_GRN] = ba;
        end
        else if (v_p >= bp_a && v_p <= bp_c)
        begin
            kind1_next[LANE_GRN] = SEG_FULL;
        end
        else if (v_p > bp_c)
        begin
            num1_next[LANE_GRN] = bd - va;
            den1_next[LANE_GRN] = bd - bc;
        end
        else
        begin
            kind1_next[LANE_GRN] = SEG_ZERO;
        end

        priority if (v_p <= bp_b)
        begin
            num1_next[LANE_BLU] = bb - va;
            den1_next[LANE_BLU] = bb - ba;
        end
        else if (v_p <= bp_d)
        begin
            kind1_next[LANE_BLU] = SEG_ZERO;
        end
        else
        begin
            num1_next[LANE_BLU] = va - bd;
            den1_next[LANE_BLU] = bmx - bd;
            hi1_next[LANE_BLU]  = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            for (int i = 0; i < LANES; i++)
            begin
                num1_reg[i]  <= num1_next[i];
                den1_reg[i]  <= den1_next[i];
                kind1_reg[i] <= kind1_next[i];
                hi1_reg[i]   <= hi1_next[i];
            end
        end
    end

    // Stage 2: make the divisor positive and scale the dividend by the
    // ceiling (255 is 256 - 1, 240 is 256 - 16). A full segment becomes
    // one over zero, which the divider reports as overflow.
    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            nm[i]   = den1_reg[i][W-1] ? -num1_reg[i] : num1_reg[i];
            dn[i]   = den1_reg[i][W-1] ? -den1_reg[i] : den1_reg[i];
            prod[i] = (RW'(DW'(nm[i])) << 8)
                    - (hi1_reg[i] ? (RW'(DW'(nm[i])) << 4) : RW'(DW'(nm[i])));
            unique case (kind1_reg[i])
                SEG_FULL:
                begin
                    num2_next[i] = RW'(1);
                    den2_next[i] = '0;
                end
                SEG_RAMP:
                begin
                    if (nm[i] <= 0)
                    begin
                        num2_next[i] = '0;
                        den2_next[i] = DW'(1);
                    end
                    else
                    begin
                        num2_next[i] = prod[i];
                        den2_next[i] = DW'(dn[i]);
                    end
                end
                default:
                begin
                    num2_next[i] = '0;
                    den2_next[i] = DW'(1);
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            for (int i = 0; i < LANES; i++)
            begin
                num2_reg[i] <= num2_next[i];
                den2_reg[i] <= den2_next[i];
                hi2_reg[i]  <= hi1_reg[i];
            end
        end
    end

    assign lane_num = num2_reg;
    assign lane_den = den2_reg;
    assign lane_hi  = hi2_reg;

endmodule

// ----- hw/rtl/tfcm_div.sv -----
// Pipelined restoring divider for one colour lane: an overflow check, then
// one quotient bit per stage, most significant first.
module tfcm_div
    import tfcm_pkg::*;
#(
    parameter int TEMP_BITS = TEMP_BITS_DEF,
    localparam int PW = TEMP_BITS + SCALE_BITS + 1,
    localparam int DW = PW,
    localparam int RW = DW + Q_BITS
)
(
    input  logic               clk,
    input  logic [Q_BITS:0]    en,
    input  logic [RW-1:0]      num_in,
    input  logic [DW-1:0]      den_in,
    input  logic               hi_in,
    output logic [Q_BITS-1:0]  quo,
    output logic               ovf,
    output logic               hi
);

    logic [RW-1:0]     rem_reg [Q_BITS];
    logic [DW-1:0]     d_reg   [Q_BITS];
    logic [Q_BITS-1:0] q_reg   [Q_BITS];
    logic              ovf_reg [Q_BITS+1];
    logic              hi_reg  [Q_BITS+1];

    // Stage 0: a quotient of 2^Q_BITS or more saturates the channel.
    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            rem_reg[0] <= num_in;
            d_reg[0]   <= den_in;
            ovf_reg[0] <= num_in >= (RW'(den_in) << Q_BITS);
            hi_reg[0]  <= hi_in;
        end
    end

    for (genvar j = 1; j <= Q_BITS; j++)
    begin : g_bit
        localparam int K = Q_BITS - j;

        logic [RW-1:0]     sub;
        logic              take;
        logic [Q_BITS-1:0] q_prev;

        if (j == 1)
        begin : g_first
            assign q_prev = '0;
        end
        else
        begin : g_rest
            assign q_prev = q_reg[j-2];
        end

        assign sub  = RW'(d_reg[j-1]) << K;
        assign take = !ovf_reg[j-1] && (rem_reg[j-1] >= sub);

        always_ff @(posedge clk)
        begin
            if (en[j])
            begin
                q_reg[j-1] <= q_prev | (Q_BITS'(take) << K);
                ovf_reg[j] <= ovf_reg[j-1];
                hi_reg[j]  <= hi_reg[j-1];
            end
        end

        if (j < Q_BITS)
        begin : g_rem
            always_ff @(posedge clk)
            begin
                if (en[j])
                begin
                    rem_reg[j] <= take ? (rem_reg[j-1] - sub) : rem_reg[j-1];
                    d_reg[j]   <= d_reg[j-1];
                end
            end
        end
    end

    assign quo = q_reg[Q_BITS-1];
    assign ovf = ovf_reg[Q_BITS];
    assign hi  = hi_reg[Q_BITS];

endmodule

// ----- hw/rtl/temperature_false_color_map.sv -----
// Thermal false-colour mapper.
//
// Each request on the input stream carries one signed temperature sample in
// s_tdata; the block answers with one pixel request on the output stream: the
// red, green and blue levels and the same colour packed as an RGB565 word.
// The colour scale runs between range_min and range_max registers, written
// through the plain configuration port (index 0 and 1); the user must write
// them only while no request is in flight (not enforced). Four breakpoints at
// fixed fractions of the span are recomputed in the cycle after every write.
//
// The pipeline is fourteen stages deep: sample offset, segment choice,
// dividend scaling, the divider overflow check, nine quotient-bit stages of
// the restoring divider and the clamp and pack register. One sample is taken
// in every cycle while the output side keeps up.
//
// Reset loads range_min with 1280 and range_max with 2560 (20 and 40
// degrees) and empties the pipeline. When the receiver stalls, the result in
// the output register holds, and earlier stages keep filling any empty slots
// behind it, so s_tready falls only once every stage is occupied.
module temperature_false_color_map
    import tfcm_pkg::*;
#(
    parameter int TEMP_BITS = TEMP_BITS_DEF,
    localparam int IN_W = ((TEMP_BITS + 7) / 8) * 8
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [TEMP_BITS-1:0]    cfg_data,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [IN_W-1:0]         s_tdata,   // sample_temp
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [PIX_BITS-1:0]     m_tdata    // red_level, green_level, blue_level,
                                               // packed_pixel
);

    localparam int PW = TEMP_BITS + SCALE_BITS + 1;
    localparam int DW = PW;
    localparam int RW = DW + Q_BITS;
    localparam int FRONT_STAGES = 3;
    localparam int DIV_STAGES = Q_BITS + 1;
    localparam int NS = FRONT_STAGES + DIV_STAGES + 1;

    logic signed [TEMP_BITS-1:0] range_min;
    logic signed [PW-1:0]        bp_a, bp_b, bp_c, bp_d, bp_max;

    logic [RW-1:0]     lane_num [LANES];
    logic [DW-1:0]     lane_den [LANES];
    logic              lane_hi  [LANES];
    logic [Q_BITS-1:0] div_q    [LANES];
    logic              div_ovf  [LANES];
    logic              div_hi   [LANES];

    // One valid bit per stage; a stage loads whenever it or any stage in front
    // of it is empty, or the receiver takes the output.
    logic [NS-1:0] valid_reg;
    logic [NS-1:0] valid_next;
    logic [NS-1:0] en;

    logic [LEVEL_BITS-1:0] level_reg  [LANES];
    logic [LEVEL_BITS-1:0] level_next [LANES];
    logic [LEVEL_BITS-1:0] top_lvl    [LANES];
    logic [15:0]           packed_pixel;

    for (genvar i = 0; i < NS; i++)
    begin : g_ready
        assign en[i] = m_tready || !(&valid_reg[NS-1:i]);
    end

    always_comb
    begin
        valid_next[0] = en[0] ? s_tvalid : valid_reg[0];
        for (int i = 1; i < NS; i++)
        begin
            valid_next[i] = en[i] ? valid_reg[i-1] : valid_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign s_tready = en[0];
    assign m_tvalid = valid_reg[NS-1];

    tfcm_bkpt #(
        .TEMP_BITS (TEMP_BITS)
    ) u_bkpt (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .range_min (range_min),
        .bp_a      (bp_a),
        .bp_b      (bp_b),
        .bp_c      (bp_c),
        .bp_d      (bp_d),
        .bp_max    (bp_max)
    );

    tfcm_front #(
        .TEMP_BITS (TEMP_BITS)
    ) u_front (
        .clk       (clk),
        .en        (en[FRONT_STAGES-1:0]),
        .sample    ($signed(s_tdata[TEMP_BITS-1:0])),
        .range_min (range_min),
        .bp_a      (bp_a),
        .bp_b      (bp_b),
        .bp_c      (bp_c),
        .bp_d      (bp_d),
        .bp_max    (bp_max),
        .lane_num  (lane_num),
        .lane_den  (lane_den),
        .lane_hi   (lane_hi)
    );

    for (genvar l = 0; l < LANES; l++)
    begin : g_lane
        tfcm_div #(
            .TEMP_BITS (TEMP_BITS)
        ) u_div (
            .clk    (clk),
            .en     (en[FRONT_STAGES +: DIV_STAGES]),
            .num_in (lane_num[l]),
            .den_in (lane_den[l]),
            .hi_in  (lane_hi[l]),
            .quo    (div_q[l]),
            .ovf    (div_ovf[l]),
            .hi     (div_hi[l])
        );
    end

    // Clamp each quotient to its channel ceiling.
    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            top_lvl[l] = div_hi[l] ? TOP_BLUE_HI : TOP_FULL;
            if (div_ovf[l] || (div_q[l] > Q_BITS'(top_lvl[l])))
            begin
                level_next[l] = top_lvl[l];
            end
            else
            begin
                level_next[l] = div_q[l][LEVEL_BITS-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[NS-1])
        begin
            for (int l = 0; l < LANES; l++)
            begin
                level_reg[l] <= level_next[l];
            end
        end
    end

    assign packed_pixel = {level_reg[LANE_RED][7:3], level_reg[LANE_GRN][7:2],
                           level_reg[LANE_BLU][7:3]};
    assign m_tdata = {packed_pixel, level_reg[LANE_BLU], level_reg[LANE_GRN],
                      level_reg[LANE_RED]};

    // An accepted sample always lands in the first stage.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> valid_reg[0])
        else $error("accepted sample did not enter the pipeline");

    // A full, stalled pipeline keeps every request where it is.
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready && !m_tready |=> $stable(valid_reg))
        else $error("stalled pipeline moved a request");

    // A request never waits behind an empty slot.
    assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[0] && !valid_reg[1] |=> valid_reg[1])
        else $error("request held behind an empty stage");

    // With no sample accepted and no result taken, the number of requests in flight holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tvalid && s_tready) && !(m_tvalid && m_tready)
        |=> $countones(valid_reg) == $past($countones(valid_reg)))
        else $error("request created or lost inside the pipeline");

endmodule

// ----- verif/temperature_false_color_map_tb.sv -----
module temperature_false_color_map_tb;

    import tfcm_pkg::*;

    localparam int PIPE_LATENCY = 13;
    // Extra cycles allowed at the end for anything still in the pipeline.
    localparam int DRAIN_CYCLES = PIPE_LATENCY + 8;
    // Generous ceiling on the whole run, in time units (10 per cycle).
    localparam int RUN_LIMIT    = 2_000_000;
    localparam int SEGMENTS     = 12;
    localparam int RANDOM_ITEMS = 49;

    // One colour result as the block reports it.
    typedef struct {
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [15:0] rgb565;
    } pixel_t;

    // Keeps its own copy of the range registers, works out the pixel that
    // each accepted sample should produce and checks results in order.
    class pixel_ledger;
        logic signed [TEMP_BITS_DEF-1:0] cold_end;
        logic signed [TEMP_BITS_DEF-1:0] hot_end;
        pixel_t pending_pixels[$];
        int     errors;

        function new();
            cold_end = TEMP_BITS_DEF'(RANGE_MIN_RESET);
            hot_end  = TEMP_BITS_DEF'(RANGE_MAX_RESET);
            errors   = 0;
        endfunction

        function void set_range(logic [CFG_IDX_BITS-1:0] idx,
                                logic [TEMP_BITS_DEF-1:0] val);
            if (idx == REG_RANGE_MIN)
                cold_end = val;
            else if (idx == REG_RANGE_MAX)
                hot_end = val;
        endfunction

        // Truncating ramp with saturation; a zero-width segment is a step,
        // and a negative width simply turns the ramp round.
        function logic [7:0] ramp_level(longint num, longint den, logic [7:0] top);
            longint q;
            longint top_l;
            top_l = top;
            if (den == 0)
                return (num > 0) ? top : 8'd0;
            if (den < 0)
            begin
                den = -den;
                num = -num;
            end
            if (num <= 0)
                return 8'd0;
            q = (num * top_l) / den;
            if (q > top_l)
                return top;
            return q[7:0];
        endfunction

        function pixel_t map_colour(logic [TEMP_BITS_DEF-1:0] sample);
            longint lo, hi, span, mn, mx, bp_a, bp_b, bp_c, bp_d, v;
            pixel_t px;
            lo   = longint'(cold_end);
            hi   = longint'(hot_end);
            span = hi - lo;
            mn   = lo * 65536;
            mx   = hi * 65536;
            bp_a = mn + span * longint'(K_A);
            bp_b = mn + span * longint'(K_B);
            bp_c = mn + span * longint'(K_C);
            bp_d = mn + span * longint'(K_D);
            v    = longint'($signed(sample)) * 65536;

            px.red = ramp_level(v - bp_b, bp_c - bp_b, TOP_FULL);

            if (v > mn && v < bp_a)
                px.green = ramp_level(v - mn, bp_a - mn, TOP_FULL);
            else if (v >= bp_a && v <= bp_c)
                px.green = TOP_FULL;
            else if (v > bp_c)
                px.green = ramp_level(bp_d - v, bp_d - bp_c, TOP_FULL);
            else
                px.green = 8'd0;

            if (v <= bp_b)
                px.blue = ramp_level(bp_b - v, bp_b - bp_a, TOP_FULL);
            else if (v <= bp_d)
                px.blue = 8'd0;
            else
                px.blue = ramp_level(v - bp_d, mx - bp_d, TOP_BLUE_HI);

            px.rgb565 = {px.red[7:3], px.green[7:2], px.blue[7:3]};
            return px;
        endfunction

        function void note_sample(logic [TEMP_BITS_DEF-1:0] sample);
            pending_pixels.push_back(map_colour(sample));
        endfunction

        function void check_pixel(logic [PIX_BITS-1:0] word);
            pixel_t want;
            if (pending_pixels.size() == 0)
            begin
                $error("pixel: result 0x%0h arrived with no sample outstanding", word);
                errors++;
                return;
            end
            want = pending_pixels.pop_front();
            if (word[7:0] !== want.red)
            begin
                $error("red_level: expected %0d, got %0d", want.red, word[7:0]);
                errors++;
            end
            if (word[15:8] !== want.green)
            begin
                $error("green_level: expected %0d, got %0d", want.green, word[15:8]);
                errors++;
            end
            if (word[23:16] !== want.blue)
            begin
                $error("blue_level: expected %0d, got %0d", want.blue, word[23:16]);
                errors++;
            end
            if (word[39:24] !== want.rgb565)
            begin
                $error("packed_pixel: expected 0x%04h, got 0x%04h", want.rgb565,
                       word[39:24]);
                errors++;
            end
        endfunction

        function int outstanding();
            return pending_pixels.size();
        endfunction
    endclass

    logic                     clk;
    logic                     rst_n;
    logic                     cfg_we;
    logic [CFG_IDX_BITS-1:0]  cfg_index;
    logic [TEMP_BITS_DEF-1:0] cfg_data;
    logic                     s_tvalid;
    logic                     s_tready;
    logic [15:0]              s_tdata;   // sample_temp
    logic                     m_tvalid;
    logic                     m_tready;
    logic [PIX_BITS-1:0]      m_tdata;   // red_level, green_level, blue_level,
                                         // packed_pixel

    // Percentage of cycles in which the sender and the receiver hold back.
    int src_idle_pct;
    int snk_idle_pct;

    pixel_ledger ledger;

    temperature_false_color_map DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // The run is abandoned if it has not finished well within this time.
    initial
    begin
        #(RUN_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
    end

    // The receiver accepts or stalls at random according to the current
    // idling mix; with a zero percentage it never stalls.
    initial
    begin
        m_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            m_tready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    // Every completed pixel request is checked against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            ledger.check_pixel(m_tdata);
    end

    // Saturates an integer temperature to the signed 16-bit sample range.
    function automatic logic [15:0] clamp_temp(int x);
        if (x < -32768)
            return 16'h8000;
        if (x > 32767)
            return 16'h7FFF;
        return x[15:0];
    endfunction

    // Temperature just at or below a breakpoint of the current scale.
    function automatic logic [15:0] breakpoint_temp(logic [15:0] k);
        longint lo, hi;
        lo = longint'(ledger.cold_end);
        hi = longint'(ledger.hot_end);
        return clamp_temp(int'(lo + (((hi - lo) * longint'(k)) >>> 16)));
    endfunction

    // Most samples fall around the configured scale, with a margin either
    // side so that the saturated ends are visited; the rest are anything.
    function automatic logic [15:0] pick_temp();
        int lo, hi, w, margin;
        if ($urandom_range(99) < 15)
            return 16'($urandom_range(16'hFFFF));
        lo = (ledger.cold_end < ledger.hot_end) ? ledger.cold_end : ledger.hot_end;
        hi = (ledger.cold_end < ledger.hot_end) ? ledger.hot_end : ledger.cold_end;
        w = hi - lo;
        margin = w / 8 + 2;
        return clamp_temp(lo - margin + int'($urandom_range(w + 2 * margin)));
    endfunction

    // Offers one sample request. The valid line is lowered only when an idle
    // gap is taken, so it is never dropped and raised in the same step.
    task automatic send_sample(input logic [15:0] sample);
        if ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < src_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= sample;
        do
            @(posedge clk);
        while (!s_tready);
        ledger.note_sample(sample);
    endtask

    // Holds the sender off until every outstanding pixel has come back,
    // lets the pipeline settle, and then rewrites both range registers.
    task automatic write_range(input logic [15:0] cold, input logic [15:0] hot);
        s_tvalid <= 1'b0;
        while (ledger.outstanding() != 0)
            @(posedge clk);
        repeat (PIPE_LATENCY + 2) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= REG_RANGE_MIN;
        cfg_data  <= cold;
        @(posedge clk);
        ledger.set_range(REG_RANGE_MIN, cold);
        cfg_index <= REG_RANGE_MAX;
        cfg_data  <= hot;
        @(posedge clk);
        ledger.set_range(REG_RANGE_MAX, hot);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        int          seg;
        int          n;
        logic [15:0] cold;
        logic [15:0] hot;

        ledger = new();
        src_idle_pct = 31;
        snk_idle_pct = 83;

        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= REG_RANGE_MIN;
        cfg_data  <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed samples on the reset scale: the extremes of the sample
        // field, both ends of the scale and their neighbours, and both sides
        // of each breakpoint.
        send_sample(16'h8000);
        send_sample(16'h7FFF);
        send_sample(16'h0000);
        send_sample(16'hFFFF);
        send_sample(clamp_temp(RANGE_MIN_RESET - 1));
        send_sample(clamp_temp(RANGE_MIN_RESET));
        send_sample(clamp_temp(RANGE_MIN_RESET + 1));
        send_sample(breakpoint_temp(K_A));
        send_sample(breakpoint_temp(K_A) + 16'd1);
        send_sample(breakpoint_temp(K_B));
        send_sample(breakpoint_temp(K_B) + 16'd1);
        send_sample(breakpoint_temp(K_C));
        send_sample(breakpoint_temp(K_C) + 16'd1);
        send_sample(breakpoint_temp(K_D));
        send_sample(breakpoint_temp(K_D) + 16'd1);
        send_sample(clamp_temp(RANGE_MAX_RESET - 1));
        send_sample(clamp_temp(RANGE_MAX_RESET));
        send_sample(clamp_temp(RANGE_MAX_RESET + 1));

        for (seg = 0; seg < SEGMENTS; seg++)
        begin
            // The idling mix changes every four segments: sender light and
            // receiver heavy, then the reverse, then no idling at all.
            if (seg == 4)
            begin
                src_idle_pct = 83;
                snk_idle_pct = 31;
            end
            else if (seg == 8)
            begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end

            // The first segment keeps the reset scale; the others cover the
            // full range, reversed ranges, a zero-width range, a one-step range,
            // a range from -640 to 6400 and random ranges.
            case (seg)
                0:
                begin
                    cold = 16'(RANGE_MIN_RESET);
                    hot  = 16'(RANGE_MAX_RESET);
                end
                1:
                begin
                    cold = 16'h8000;
                    hot  = 16'h7FFF;
                end
                2:
                begin
                    cold = 16'h7FFF;
                    hot  = 16'h8000;
                end
                3:
                begin
                    cold = 16'd500;
                    hot  = 16'd500;
                end
                4:
                begin
                    cold = 16'd0;
                    hot  = 16'd1;
                end
                5:
                begin
                    cold = clamp_temp(-640);
                    hot  = 16'd6400;
                end
                6:
                begin
                    cold = 16'd100;
                    hot  = clamp_temp(-100);
                end
                default:
                begin
                    cold = 16'($urandom_range(16'hFFFF));
                    hot  = 16'($urandom_range(16'hFFFF));
                end
            endcase
            if (seg != 0)
                write_range(cold, hot);

            for (n = 0; n < RANDOM_ITEMS; n++)
                send_sample(pick_temp());
        end

        s_tvalid <= 1'b0;
        while (ledger.outstanding() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (ledger.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
